>>> rtl/motor_pulse_sequencer_assert.svh
// ----------------------------------------------------------------------------
// motor_pulse_sequencer assertion macros
// Shared property shorthands for the sequencer checkers.
// ----------------------------------------------------------------------------
`ifndef MOTOR_PULSE_SEQUENCER_ASSERT_SVH
`define MOTOR_PULSE_SEQUENCER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define MPS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define MPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/mps_pkg.sv
// ----------------------------------------------------------------------------
// mps_pkg
// Types, codes and pulse tables shared by the motor pulse sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mps_pkg;

	// pulse phase
	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_ON    = 2'd1,
		PH_COAST = 2'd2
	} phase_t;

	// operation codes
	typedef enum logic [1:0] {
		OP_FIRE  = 2'd0,
		OP_ABORT = 2'd1,
		OP_TICK  = 2'd2
	} op_t;

	// register indexes (byte address bit 2)
	localparam logic REG_DUTY_LIMIT = 1'b0;
	localparam logic REG_COAST_TIME = 1'b1;

	localparam logic [14:0] DUTY_LIMIT_RST = 15'd1000;
	localparam logic [15:0] COAST_TIME_RST = 16'd500;

	// usable entries per axis table, and entries actually stored
	localparam logic [4:0] TABLE_LENGTH   = 5'd8;
	localparam logic [4:0] STORED_ENTRIES = 5'd8;

	localparam logic [15:0] LUT_DUTY [2][8] = '{
		'{16'd160, 16'd220, 16'd300, 16'd400, 16'd520, 16'd700, 16'd920, 16'd1200},
		'{16'd180, 16'd240, 16'd320, 16'd420, 16'd560, 16'd740, 16'd980, 16'd1280}
	};
	localparam logic [15:0] LUT_ON [2][8] = '{
		'{16'd2000, 16'd2000, 16'd3000, 16'd3000, 16'd4000, 16'd5000, 16'd7000, 16'd10000},
		'{16'd2000, 16'd2000, 16'd3000, 16'd3000, 16'd4000, 16'd5000, 16'd7000, 16'd10000}
	};

	typedef struct packed {
		logic [1:0]        operation;
		logic              axis;
		logic signed [1:0] sign;
		logic [3:0]        index;
	} item_t;

	typedef struct packed {
		logic [14:0] duty_limit;
		logic [15:0] coast_time;
	} cfg_t;

	typedef struct packed {
		logic               rejected;
		logic               drive_write;
		logic               drive_axis;
		logic signed [15:0] drive_duty;
		logic               busy_res;
	} res_t;

endpackage

>>> rtl/mps_regs.sv
// ----------------------------------------------------------------------------
// mps_regs
// APB configuration registers: duty limit and coast time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mps_regs (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	output mps_pkg::cfg_t cfg
);

	logic [14:0] duty_limit_q;
	logic [15:0] coast_time_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// register write on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_limit_q <= mps_pkg::DUTY_LIMIT_RST;
			coast_time_q <= mps_pkg::COAST_TIME_RST;
		end else if (wr_en) begin
			case (paddr[2])
				mps_pkg::REG_DUTY_LIMIT: duty_limit_q <= pwdata[14:0];
				mps_pkg::REG_COAST_TIME: coast_time_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// read back; low address bits are don't-care
	always_comb begin
		case (paddr[2])
			mps_pkg::REG_DUTY_LIMIT: prdata = {17'd0, duty_limit_q};
			mps_pkg::REG_COAST_TIME: prdata = {16'd0, coast_time_q};
			default:                 prdata = 32'd0;
		endcase
	end

	assign cfg.duty_limit = duty_limit_q;
	assign cfg.coast_time = coast_time_q;

endmodule

>>> rtl/mps_core.sv
// ----------------------------------------------------------------------------
// mps_core
// Pulse state and the step logic: fire, abort and tick handling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mps_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  mps_pkg::item_t item,
	input  mps_pkg::cfg_t  cfg,
	output mps_pkg::res_t  res
);

	mps_pkg::phase_t phase_q, phase_d;
	logic            pulse_axis_q, pulse_axis_d;
	logic [15:0]     rem_q, rem_d;

	logic [15:0] tbl_duty, tbl_on, duty_mag, duty_signed;
	logic [15:0] rem_dec, coast_load;
	logic        fire_bad;

	// table lookup, clamp to 1..duty_limit, apply sign
	always_comb begin
		tbl_duty = mps_pkg::LUT_DUTY[item.axis][item.index[2:0]];
		tbl_on   = mps_pkg::LUT_ON[item.axis][item.index[2:0]];
		duty_mag = (tbl_duty == 16'd0) ? 16'd1 : tbl_duty;
		if (duty_mag > {1'b0, cfg.duty_limit})
			duty_mag = {1'b0, cfg.duty_limit};
		duty_signed = item.sign[1] ? 16'(16'd0 - duty_mag) : duty_mag;
	end

	assign fire_bad = ({1'b0, item.index} >= mps_pkg::TABLE_LENGTH)
		|| ({1'b0, item.index} >= mps_pkg::STORED_ENTRIES)
		|| (phase_q != mps_pkg::PH_IDLE)
		|| (item.sign == 2'sd0);

	assign rem_dec    = (rem_q != 16'd0) ? 16'(rem_q - 16'd1) : rem_q;
	assign coast_load = (cfg.coast_time == 16'd0) ? 16'd1 : cfg.coast_time;

	// next state and result of one step
	always_comb begin
		phase_d         = phase_q;
		pulse_axis_d    = pulse_axis_q;
		rem_d           = rem_q;
		res.rejected    = 1'b0;
		res.drive_write = 1'b0;
		res.drive_axis  = 1'b0;
		res.drive_duty  = 16'sd0;
		case (mps_pkg::op_t'(item.operation))
			mps_pkg::OP_FIRE: begin
				if (fire_bad) begin
					res.rejected = 1'b1;
				end else begin
					pulse_axis_d    = item.axis;
					rem_d           = (tbl_on == 16'd0) ? 16'd1 : tbl_on;
					phase_d         = mps_pkg::PH_ON;
					res.drive_write = 1'b1;
					res.drive_axis  = item.axis;
					res.drive_duty  = duty_signed;
				end
			end
			mps_pkg::OP_ABORT: begin
				if (phase_q != mps_pkg::PH_IDLE) begin
					res.drive_write = 1'b1;
					res.drive_axis  = pulse_axis_q;
					phase_d         = mps_pkg::PH_IDLE;
					rem_d           = 16'd0;
				end
			end
			mps_pkg::OP_TICK: begin
				if (phase_q != mps_pkg::PH_IDLE) begin
					rem_d = rem_dec;
					if (phase_q == mps_pkg::PH_ON) begin
						// on-time over: stop drive, start coast
						if (rem_dec == 16'd0) begin
							res.drive_write = 1'b1;
							res.drive_axis  = pulse_axis_q;
							phase_d         = mps_pkg::PH_COAST;
							rem_d           = coast_load;
						end
					end else if (rem_dec == 16'd0) begin
						phase_d = mps_pkg::PH_IDLE;
					end
				end
			end
			default: ;
		endcase
		res.busy_res = (phase_d != mps_pkg::PH_IDLE);
	end

	// state update when the staged beat is consumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= mps_pkg::PH_IDLE;
			pulse_axis_q <= 1'b0;
			rem_q        <= 16'd0;
		end else if (step) begin
			phase_q      <= phase_d;
			pulse_axis_q <= pulse_axis_d;
			rem_q        <= rem_d;
		end
	end

endmodule

>>> rtl/motor_pulse_sequencer.sv
// Path: an accepted input beat is held in the input register, its result in the result register.
// Throughput: one input beat per cycle while results are taken; a stalled result
//   holds the result register, and the input register takes one more beat before
//   in_ready drops.
// Reset: arst_n clears pulse state to idle and restores the register defaults.
// ----------------------------------------------------------------------------
// motor_pulse_sequencer
// Timed motor drive pulse sequencer with APB configuration.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module motor_pulse_sequencer (
	input  logic               clk,
	input  logic               arst_n,
	// APB configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// input channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         operation,
	input  logic               axis,
	input  logic signed [1:0]  sign,
	input  logic [3:0]         index,
	// result channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic               rejected,
	output logic               drive_write,
	output logic               drive_axis,
	output logic signed [15:0] drive_duty,
	output logic               busy_res
);

	mps_pkg::cfg_t  cfg;
	mps_pkg::item_t item_s1;
	mps_pkg::res_t  res_comb, res_s2;
	logic           vld_s1, vld_s2;
	logic           adv_s2, step;

	mps_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// handshake: result stage frees when empty or taken
	assign adv_s2   = !vld_s2 || out_ready;
	assign step     = vld_s1 && adv_s2;
	assign in_ready = !vld_s1 || adv_s2;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.operation <= operation;
			item_s1.axis      <= axis;
			item_s1.sign      <= sign;
			item_s1.index     <= index;
		end
	end

	mps_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res_comb)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= res_comb;
		end
	end

	assign out_valid   = vld_s2;
	assign rejected    = res_s2.rejected;
	assign drive_write = res_s2.drive_write;
	assign drive_axis  = res_s2.drive_axis;
	assign drive_duty  = res_s2.drive_duty;
	assign busy_res    = res_s2.busy_res;

endmodule

>>> rtl/mps_checker.sv
// ----------------------------------------------------------------------------
// mps_checker
// Port-level checks on the sequencer result channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "motor_pulse_sequencer_assert.svh"

module mps_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic               rejected,
	input logic               drive_write,
	input logic               drive_axis,
	input logic signed [15:0] drive_duty,
	input logic               busy_res
);

	// a stalled result beat holds
	`MPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(drive_duty) && $stable(busy_res), "result beat changed while stalled")

	// no write means no axis and zero duty
	`MPS_ASSERT_IMPL(a_no_write_quiet, out_valid && !drive_write, drive_duty == 16'sd0 && !drive_axis, "drive fields set without a write")

	// a refused fire writes nothing
	`MPS_ASSERT_IMPL(a_reject_no_write, out_valid && rejected, !drive_write, "rejected fire wrote the drive")

	// a nonzero duty write starts a pulse
	`MPS_ASSERT_IMPL(a_pulse_busy, out_valid && drive_write && drive_duty != 16'sd0, busy_res && !rejected, "pulse start not busy")

endmodule

bind motor_pulse_sequencer mps_checker u_mps_checker (.*);
